// ===== hdl/geo_pkg.sv =====
// Shared widths, constants, beat types and the arctangent table of the geodetic converter.
package geo_pkg;

  // Field and datapath widths
  localparam int unsigned AngW   = 32;  // binary angle
  localparam int unsigned HW     = 28;  // height in mm
  localparam int unsigned OutW   = 34;  // ECEF coordinate in mm
  localparam int unsigned SemiW  = 33;  // semi-major axis in mm
  localparam int unsigned FlatW  = 34;  // flattening, Q40
  localparam int unsigned CfgW   = 34;  // widest register
  localparam int unsigned E2W    = 36;  // e2, Q40
  localparam int unsigned OmeW   = 41;  // 1 - e2, Q40
  localparam int unsigned XW     = 43;  // rotator vector, Q40 plus growth
  localparam int unsigned ZW     = 34;  // residual angle
  localparam int unsigned TrigW  = 33;  // sine and cosine, Q30
  localparam int unsigned SqW    = 63;  // radicand 4d
  localparam int unsigned RootW  = 32;  // square root, Q31
  localparam int unsigned QuoW   = 50;  // prime-vertical radius, Q16 mm
  localparam int unsigned PosW   = 52;  // Q16 mm positions

  // Rotator start vector: the inverse gain in Q40
  localparam logic signed [XW-1:0] X0 = XW'(64'd667681662976);

  // Configuration register indexes
  localparam logic CfgSemiMajor  = 1'b0;
  localparam logic CfgFlattening = 1'b1;

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam int unsigned AtanLen = 48;
  localparam logic [31:0] AtanTab [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // One rotator lane
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // Data riding along the rotator row
  typedef struct packed {
    logic                 flip_lat;
    logic                 flip_lon;
    logic signed [HW-1:0] h;
  } tag_t;

  // Square root cell beat
  typedef struct packed {
    logic [SqW-1:0]   rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  // Divider cell beat
  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [RootW-1:0] den;
    logic [QuoW-1:0]  quo;
    logic [2:0]       abits;
  } div_t;

  // Trig results and height carried past the radius unit
  typedef struct packed {
    logic signed [TrigW-1:0] sl;
    logic signed [TrigW-1:0] cl;
    logic signed [TrigW-1:0] so;
    logic signed [TrigW-1:0] co;
    logic signed [HW-1:0]    h;
  } side_t;

endpackage

// ===== hdl/geodetic_to_ecef.sv =====
// Top level: geodetic latitude, longitude and height to ECEF X, Y, Z in mm.
//
// Usage: drive latitude, longitude and height with start high; a beat is taken
// at every rising edge with start high, since busy stays low. One beat can be
// issued in every cycle.
// Each beat yields one result: done_o is high for exactly one cycle with X, Y, Z
// on the result ports. Results come out in issue order.
// Each beat passes through the row of rotator cells, the 32 cells of the square
// root, the 50 cells of the divider and the final multiplier stages. Throughput
// is one beat per clock.
// The receiver cannot stall: a result is valid for one cycle only.
// Configuration: write semi-major axis (index 0) or flattening (index 1) with
// cfg_we_i while no beat is in flight; e2 and 1 - e2 are then re-formed through the product registers.
// Reset clears the pipeline valid flags and loads the WGS-84 ellipsoid.
module geodetic_to_ecef #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [geo_pkg::AngW-1:0]    latitude_angle_i,
  input  logic signed [geo_pkg::AngW-1:0]    longitude_angle_i,
  input  logic signed [geo_pkg::HW-1:0]      height_mm_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [geo_pkg::CfgW-1:0]           cfg_data_i,
  output logic                               done_o,
  output logic signed [geo_pkg::OutW-1:0]    ecef_x_mm_o,
  output logic signed [geo_pkg::OutW-1:0]    ecef_y_mm_o,
  output logic signed [geo_pkg::OutW-1:0]    ecef_z_mm_o
);
  import geo_pkg::*;

  localparam int unsigned LineLen = 2 + RootW + QuoW;
  localparam logic signed [PosW-1:0] OutLimit = PosW'(64'sd8000000000);

  // Saturate a Q16 value to whole millimetres
  function automatic logic signed [OutW-1:0] sat_mm(input logic signed [PosW-1:0] v);
    logic signed [PosW-1:0] t;
    t = (v + PosW'(32768)) >>> 16;
    if (t > OutLimit) begin
      t = OutLimit;
    end else if (t < -OutLimit) begin
      t = -OutLimit;
    end
    return t[OutW-1:0];
  endfunction

  // Configuration registers
  logic [SemiW-1:0] semi_q;
  logic [FlatW-1:0] flat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semi_q <= SemiW'(64'd6378137000);
      flat_q <= FlatW'(64'd3686454300);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSemiMajor:  semi_q <= cfg_data_i[SemiW-1:0];
        CfgFlattening: flat_q <= cfg_data_i[FlatW-1:0];
        default:       semi_q <= semi_q;
      endcase
    end
  end

  // Form e2 = 2f - f^2 and 1 - e2 from the flattening
  logic [27:0]     pa_q;
  logic [33:0]     pb_q;
  logic [39:0]     pc_q;
  logic [E2W-1:0]  f2, e2_d, e2_q;
  logic [OmeW-1:0] ome2_q;

  always_comb begin
    f2   = E2W'(pa_q) + E2W'(((64'(pb_q) << 21) + 64'(pc_q)) >> 40);
    e2_d = E2W'({flat_q, 1'b0}) - f2;
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= 28'(flat_q[33:20]) * 28'(flat_q[33:20]);
    pb_q   <= 34'(flat_q[33:20]) * 34'(flat_q[19:0]);
    pc_q   <= 40'(flat_q[19:0]) * 40'(flat_q[19:0]);
    e2_q   <= e2_d;
    ome2_q <= (OmeW'(1) << 40) - OmeW'(e2_d);
  end

  assign busy = 1'b0;

  // Fold both angles into the half-plane the rotator covers
  logic       pre_valid_q;
  rot_t [1:0] pre_rot_q;
  tag_t       pre_tag_q;
  logic       flip_lat, flip_lon;

  assign flip_lat = latitude_angle_i[AngW-1] ^ latitude_angle_i[AngW-2];
  assign flip_lon = longitude_angle_i[AngW-1] ^ longitude_angle_i[AngW-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else begin
      pre_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_rot_q[0].x <= X0;
    pre_rot_q[0].y <= '0;
    pre_rot_q[0].z <= ZW'(signed'({latitude_angle_i[AngW-1] ^ flip_lat,
                                   latitude_angle_i[AngW-2:0]}));
    pre_rot_q[1].x <= X0;
    pre_rot_q[1].y <= '0;
    pre_rot_q[1].z <= ZW'(signed'({longitude_angle_i[AngW-1] ^ flip_lon,
                                   longitude_angle_i[AngW-2:0]}));
    pre_tag_q.flip_lat <= flip_lat;
    pre_tag_q.flip_lon <= flip_lon;
    pre_tag_q.h        <= height_mm_i;
  end

  // Row of rotator cells
  logic       cv   [CORDIC_STAGES+1];
  rot_t [1:0] crot [CORDIC_STAGES+1];
  tag_t       ctag [CORDIC_STAGES+1];

  assign cv[0]   = pre_valid_q;
  assign crot[0] = pre_rot_q;
  assign ctag[0] = pre_tag_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    geo_cordic_cell #(.Stage(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cv[g]),
      .rot_i  (crot[g]),
      .tag_i  (ctag[g]),
      .valid_o(cv[g+1]),
      .rot_o  (crot[g+1]),
      .tag_o  (ctag[g+1])
    );
  end

  // Round to Q30 and undo the half-turn fold
  logic                  r_valid_q;
  side_t                 r_d, r_q;
  logic signed [XW-1:0]  rx0, ry0, rx1, ry1;
  logic signed [TrigW-1:0] cl_t, sl_t, co_t, so_t;

  always_comb begin
    rx0  = (crot[CORDIC_STAGES][0].x + XW'(512)) >>> 10;
    ry0  = (crot[CORDIC_STAGES][0].y + XW'(512)) >>> 10;
    rx1  = (crot[CORDIC_STAGES][1].x + XW'(512)) >>> 10;
    ry1  = (crot[CORDIC_STAGES][1].y + XW'(512)) >>> 10;
    cl_t = rx0[TrigW-1:0];
    sl_t = ry0[TrigW-1:0];
    co_t = rx1[TrigW-1:0];
    so_t = ry1[TrigW-1:0];
    r_d.cl = ctag[CORDIC_STAGES].flip_lat ? -cl_t : cl_t;
    r_d.sl = ctag[CORDIC_STAGES].flip_lat ? -sl_t : sl_t;
    r_d.co = ctag[CORDIC_STAGES].flip_lon ? -co_t : co_t;
    r_d.so = ctag[CORDIC_STAGES].flip_lon ? -so_t : so_t;
    r_d.h  = ctag[CORDIC_STAGES].h;
  end

  // Square sin lat, then form the radicand 4(1 - e2 sin^2 lat)
  logic                      s2_valid_q, w_valid_q;
  logic signed [2*TrigW-1:0] sq_full;
  logic [61:0]               s2_q;
  logic [63:0]               wprod;
  logic [60:0]               dd;
  logic [SqW-1:0]            v_q;

  always_comb begin
    sq_full = r_q.sl * r_q.sl;
    wprod   = 64'(e2_q) * 64'(s2_q[61:34]);
    dd      = (61'(1) << 60) - 61'(wprod >> 6);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      w_valid_q  <= 1'b0;
    end else begin
      r_valid_q  <= cv[CORDIC_STAGES];
      s2_valid_q <= r_valid_q;
      w_valid_q  <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    s2_q <= sq_full[61:0];
    v_q  <= {dd, 2'b00};
  end

  // Delay line for the trig results past the radius unit
  side_t line_q [LineLen];

  always_ff @(posedge clk_i) begin
    line_q[0] <= r_q;
    for (int j = 1; j < LineLen; j++) begin
      line_q[j] <= line_q[j-1];
    end
  end

  // Square root cells, most significant root bit first
  logic  sv [RootW+1];
  sqrt_t sd [RootW+1];

  assign sv[0]      = w_valid_q;
  assign sd[0].rem  = v_q;
  assign sd[0].root = '0;

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    geo_sqrt_cell #(.Bit(RootW - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sv[k]),
      .sq_i   (sd[k]),
      .valid_o(sv[k+1]),
      .sq_o   (sd[k+1])
    );
  end

  // Divider cells: N = a * 2^47 / r in Q16 mm
  logic dvv [QuoW+1];
  div_t dvd [QuoW+1];

  assign dvv[0]       = sv[RootW];
  assign dvd[0].rem   = RootW'(semi_q[SemiW-1:3]);
  assign dvd[0].den   = sd[RootW].root;
  assign dvd[0].quo   = '0;
  assign dvd[0].abits = semi_q[2:0];

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    geo_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dvv[k]),
      .dv_i   (dvd[k]),
      .valid_o(dvv[k+1]),
      .dv_o   (dvd[k+1])
    );
  end

  // Output stages: radii, rotation products and saturation
  logic [6:1]             ov_q;
  side_t                  s1_q, s2s_q, s3_q;
  logic signed [43:0]     h16_0, h16_2;
  logic signed [PosW-1:0] nh_q, nz_q, xc, px, py, pz;
  logic signed [QuoW:0]   nzm;
  logic signed [OutW-1:0] x_q, y_q, z_q;

  assign h16_0 = {line_q[LineLen-1].h, 16'h0000};
  assign h16_2 = {s2s_q.h, 16'h0000};

  geo_mul_rnd #(.AW(QuoW + 1), .BW(OmeW + 1), .SH(40), .RW(QuoW + 1)) u_mul_nz (
    .clk_i(clk_i),
    .a_i  (signed'({1'b0, dvd[QuoW].quo})),
    .b_i  (signed'({1'b0, ome2_q})),
    .p_o  (nzm)
  );

  geo_mul_rnd #(.AW(PosW), .BW(TrigW), .SH(30), .RW(PosW)) u_mul_xc (
    .clk_i(clk_i),
    .a_i  (nh_q),
    .b_i  (s1_q.cl),
    .p_o  (xc)
  );

  geo_mul_rnd #(.AW(PosW), .BW(TrigW), .SH(30), .RW(PosW)) u_mul_x (
    .clk_i(clk_i),
    .a_i  (xc),
    .b_i  (s3_q.co),
    .p_o  (px)
  );

  geo_mul_rnd #(.AW(PosW), .BW(TrigW), .SH(30), .RW(PosW)) u_mul_y (
    .clk_i(clk_i),
    .a_i  (xc),
    .b_i  (s3_q.so),
    .p_o  (py)
  );

  geo_mul_rnd #(.AW(PosW), .BW(TrigW), .SH(30), .RW(PosW)) u_mul_z (
    .clk_i(clk_i),
    .a_i  (nz_q),
    .b_i  (s3_q.sl),
    .p_o  (pz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= '0;
    end else begin
      ov_q <= {ov_q[5:1], dvv[QuoW]};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= line_q[LineLen-1];
    s2s_q <= s1_q;
    s3_q  <= s2s_q;
    nh_q  <= signed'({2'b00, dvd[QuoW].quo}) + PosW'(h16_0);
    nz_q  <= PosW'(nzm) + PosW'(h16_2);
    x_q   <= sat_mm(px);
    y_q   <= sat_mm(py);
    z_q   <= sat_mm(pz);
  end

  assign done_o      = ov_q[6];
  assign ecef_x_mm_o = x_q;
  assign ecef_y_mm_o = y_q;
  assign ecef_z_mm_o = z_q;

endmodule

// ===== hdl/geo_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation for the latitude and longitude lanes.
module geo_cordic_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  geo_pkg::rot_t [1:0]   rot_i,
  input  geo_pkg::tag_t         tag_i,
  output logic                  valid_o,
  output geo_pkg::rot_t [1:0]   rot_o,
  output geo_pkg::tag_t         tag_o
);
  import geo_pkg::*;

  localparam logic signed [ZW-1:0] Atan = ZW'(AtanTab[Stage]);

  logic        valid_q;
  rot_t [1:0]  rot_d, rot_q;
  tag_t        tag_q;

  // Rotate each lane toward zero residual angle
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!rot_i[l].z[ZW-1]) begin
        rot_d[l].x = rot_i[l].x - (rot_i[l].y >>> Stage);
        rot_d[l].y = rot_i[l].y + (rot_i[l].x >>> Stage);
        rot_d[l].z = rot_i[l].z - Atan;
      end else begin
        rot_d[l].x = rot_i[l].x + (rot_i[l].y >>> Stage);
        rot_d[l].y = rot_i[l].y - (rot_i[l].x >>> Stage);
        rot_d[l].z = rot_i[l].z + Atan;
      end
    end
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hand the beat to the next cell
  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
    tag_q <= tag_i;
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign tag_o   = tag_q;

endmodule

// ===== hdl/geo_sqrt_cell.sv =====
// One root bit of the pipelined integer square root.
module geo_sqrt_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  geo_pkg::sqrt_t  sq_i,
  output logic            valid_o,
  output geo_pkg::sqrt_t  sq_o
);
  import geo_pkg::*;

  localparam int unsigned TW = SqW + 2;

  logic          valid_q;
  logic [TW-1:0] trial, rem_x;
  sqrt_t         sq_d, sq_q;

  // Keep the bit when (root + 2^Bit)^2 still fits under the radicand
  always_comb begin
    trial = (TW'(sq_i.root) << (Bit + 1)) + (TW'(1) << (2 * Bit));
    rem_x = TW'(sq_i.rem);
    sq_d  = sq_i;
    if (rem_x >= trial) begin
      sq_d.rem  = sq_i.rem - trial[SqW-1:0];
      sq_d.root = sq_i.root | (RootW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;

endmodule

// ===== hdl/geo_div_cell.sv =====
// One quotient bit of the pipelined restoring divider.
module geo_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  geo_pkg::div_t  dv_i,
  output logic           valid_o,
  output geo_pkg::div_t  dv_o
);
  import geo_pkg::*;

  logic             valid_q;
  logic [RootW:0]   trial;
  div_t             dv_d, dv_q;

  // Shift in the next dividend bit and subtract the divisor when it fits
  always_comb begin
    trial       = {dv_i.rem, dv_i.abits[2]};
    dv_d.den    = dv_i.den;
    dv_d.abits  = {dv_i.abits[1:0], 1'b0};
    if (trial >= {1'b0, dv_i.den}) begin
      dv_d.rem = RootW'(trial - {1'b0, dv_i.den});
      dv_d.quo = {dv_i.quo[QuoW-2:0], 1'b1};
    end else begin
      dv_d.rem = trial[RootW-1:0];
      dv_d.quo = {dv_i.quo[QuoW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
  end

  assign valid_o = valid_q;
  assign dv_o    = dv_q;

endmodule

// ===== hdl/geo_mul_rnd.sv =====
// Two-stage signed multiplier with round-half-away-from-zero right shift.
module geo_mul_rnd #(
  parameter int unsigned AW = 52,
  parameter int unsigned BW = 33,
  parameter int unsigned SH = 30,
  parameter int unsigned RW = 52
) (
  input  logic                 clk_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [RW-1:0] p_o
);

  localparam int unsigned LW = AW / 2;
  localparam int unsigned UW = AW - LW;
  localparam int unsigned PW = AW + BW;

  logic [AW-1:0]    ua;
  logic [BW-1:0]    ub;
  logic [UW+BW-1:0] ph_d, ph_q;
  logic [LW+BW-1:0] pl_d, pl_q;
  logic             neg_q;
  logic [PW-1:0]    sum;
  logic [PW-SH-1:0] mag;
  logic signed [RW-1:0] p_d, p_q;

  // Split the magnitude of a into two partial products
  always_comb begin
    ua   = a_i[AW-1] ? (~a_i + 1'b1) : a_i;
    ub   = b_i[BW-1] ? (~b_i + 1'b1) : b_i;
    ph_d = (UW+BW)'(ua[AW-1:LW]) * (UW+BW)'(ub);
    pl_d = (LW+BW)'(ua[LW-1:0]) * (LW+BW)'(ub);
  end

  // Merge, round the magnitude, then apply the sign
  always_comb begin
    sum = (PW'(ph_q) << LW) + PW'(pl_q) + (PW'(1) << (SH - 1));
    mag = sum[PW-1:SH];
    p_d = neg_q ? -RW'(mag) : RW'(mag);
  end

  always_ff @(posedge clk_i) begin
    ph_q  <= ph_d;
    pl_q  <= pl_d;
    neg_q <= a_i[AW-1] ^ b_i[BW-1];
    p_q   <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== verif/tb_geodetic_to_ecef.sv =====
// Self-checking testbench of the geodetic to ECEF converter, with its own bit-true predictor.
`timescale 1ns / 1ps

module tb_geodetic_to_ecef;
  import geo_pkg::*;

  localparam int unsigned Stages     = 32;
  localparam int unsigned Latency    = Stages + 92;
  localparam longint      CycleLimit = 400000;
  localparam longint      OutLimit   = 64'sd8000000000;
  localparam int          RandItems  = 1320;

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam longint AtanTurn [48] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] z;
  } ecef_t;

  // Directed row: X is typed in only for the saturation rows
  typedef struct {
    logic [31:0]   lat;
    logic [31:0]   lon;
    logic [HW-1:0] h;
    bit            sat;
    longint        x_sat;
  } row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic signed [AngW-1:0] latitude_angle_i;
  logic signed [AngW-1:0] longitude_angle_i;
  logic signed [HW-1:0]   height_mm_i;
  logic                   cfg_we_i;
  logic                   cfg_idx_i;
  logic [CfgW-1:0]        cfg_data_i;
  logic                   done_o;
  logic signed [OutW-1:0] ecef_x_mm_o;
  logic signed [OutW-1:0] ecef_y_mm_o;
  logic signed [OutW-1:0] ecef_z_mm_o;

  geodetic_to_ecef #(.CORDIC_STAGES(Stages)) uut (.*);

  // Predictor copy of the ellipsoid registers
  logic [SemiW-1:0] axis_mm;
  logic [FlatW-1:0] flat_q40;

  ecef_t  pending_ecef[$];
  bit     typed_x_next;
  longint typed_x_val;
  int     errors;
  int     positions_sent;
  int     positions_checked;
  longint cycles;
  int     idle_pct;

  function automatic void sincos_q30(input logic [31:0] ang, output longint s,
                                     output longint c);
    logic [31:0] u;
    bit          flip;
    longint      x, y, z, dx, dy;
    u = ang;
    flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
    if (flip) u = u + 32'h8000_0000;
    z = longint'($signed(u));
    x = 64'sd2608131496 * 256;
    y = 0;
    for (int i = 0; i < Stages && i < 48; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - AtanTurn[i];
      end else begin
        x = x + dx; y = y - dy; z = z + AtanTurn[i];
      end
    end
    x = (x + 512) >>> 10;
    y = (y + 512) >>> 10;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Round |a*b| / 2^sh to nearest, halves away from zero, then apply the sign
  function automatic longint round_mul(input longint a, input longint b, input int sh);
    logic [63:0]  ua, ub, res;
    logic [127:0] p;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    res = p[63:0];
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [OutW-1:0] q16_to_mm(input longint v);
    longint mm;
    mm = (v + 32768) >>> 16;
    if (mm > OutLimit) mm = OutLimit;
    if (mm < -OutLimit) mm = -OutLimit;
    return mm[OutW-1:0];
  endfunction

  function automatic ecef_t convert_position(input logic [31:0] lat, input logic [31:0] lon,
                                             input logic [HW-1:0] h);
    logic [127:0] ff;
    logic [63:0]  f, e2, s2, w, d, r, num, q, rem;
    longint       one_m_e2, sl, cl, so, co, h16, n16, nh, nz, xc;
    ecef_t        res;
    f = {30'd0, flat_q40};
    ff = {64'd0, f} * {64'd0, f};
    e2 = 2 * f - ff[103:40];
    one_m_e2 = (64'sd1 <<< 40) - longint'(e2);
    sincos_q30(lat, sl, cl);
    sincos_q30(lon, so, co);
    s2 = sl * sl;
    w = (e2 * (s2 >> 34)) >> 6;
    d = (64'd1 << 60) - w;
    r = root_floor(d << 2);
    num = {31'd0, axis_mm} << 31;
    q = num / r;
    rem = num % r;
    n16 = longint'((q << 16) + ((rem << 16) / r));
    h16 = longint'($signed(h)) * 65536;
    nh = n16 + h16;
    nz = round_mul(n16, one_m_e2, 40) + h16;
    xc = round_mul(nh, cl, 30);
    res.x = q16_to_mm(round_mul(xc, co, 30));
    res.y = q16_to_mm(round_mul(xc, so, 30));
    res.z = q16_to_mm(round_mul(nz, sl, 30));
    return res;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Track accepted beats and register writes, check every result beat
  always @(posedge clk_i) begin
    ecef_t exp_pos;
    cycles <= cycles + 1;
    if (rst_ni && cfg_we_i) begin
      if (cfg_idx_i == CfgSemiMajor) axis_mm = cfg_data_i[SemiW-1:0];
      else                           flat_q40 = cfg_data_i[FlatW-1:0];
    end
    if (rst_ni && start && !busy) begin
      exp_pos = convert_position(latitude_angle_i, longitude_angle_i, height_mm_i);
      if (typed_x_next) exp_pos.x = typed_x_val[OutW-1:0];
      pending_ecef.push_back(exp_pos);
    end
    if (rst_ni && done_o) begin
      if (pending_ecef.size() == 0) begin
        $display("%0t: result with nothing expected: x=%0d y=%0d z=%0d", $time,
                 ecef_x_mm_o, ecef_y_mm_o, ecef_z_mm_o);
        errors++;
      end else begin
        exp_pos = pending_ecef.pop_front();
        positions_checked++;
        if (ecef_x_mm_o !== exp_pos.x) begin
          $display("%0t: X mismatch: expected %0d, got %0d", $time, exp_pos.x, ecef_x_mm_o);
          errors++;
        end
        if (ecef_y_mm_o !== exp_pos.y) begin
          $display("%0t: Y mismatch: expected %0d, got %0d", $time, exp_pos.y, ecef_y_mm_o);
          errors++;
        end
        if (ecef_z_mm_o !== exp_pos.z) begin
          $display("%0t: Z mismatch: expected %0d, got %0d", $time, exp_pos.z, ecef_z_mm_o);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_ecef.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive one position beat and hold it until taken
  task automatic send_position(input logic [31:0] lat, input logic [31:0] lon,
                               input logic [HW-1:0] h);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    latitude_angle_i = lat;
    longitude_angle_i = lon;
    height_mm_i = h;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    positions_sent++;
    @(negedge clk_i);
  endtask

  // Let the pipeline drain, then settle past the latency
  task automatic drain;
    start = 1'b0;
    while (pending_ecef.size() != 0) @(negedge clk_i);
    repeat (Latency + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_random(input int n);
    logic [31:0]   lat, lon;
    logic [HW-1:0] h;
    for (int i = 0; i < n; i++) begin
      lon = $urandom;
      // Mostly legal latitudes and heights, some raw bit patterns
      if ($urandom_range(9) < 8) lat = $urandom_range(32'h8000_0000) - 32'h4000_0000;
      else lat = $urandom;
      if ($urandom_range(9) < 8) h = HW'($urandom_range(110000000) - 10000000);
      else h = HW'($urandom);
      send_position(lat, lon, h);
    end
  endtask

  row_t dir_rows[$];

  initial begin
    row_t   rw;
    int     per;
    errors = 0;
    positions_sent = 0;
    positions_checked = 0;
    cycles = 0;
    idle_pct = 0;
    typed_x_next = 1'b0;
    typed_x_val = 0;
    axis_mm = 33'd6378137000;
    flat_q40 = 34'd3686454300;
    start = 1'b0;
    latitude_angle_i = '0;
    longitude_angle_i = '0;
    height_mm_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgSemiMajor;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Field extremes, quadrant boundaries and raw latitude patterns on WGS-84
    dir_rows = '{
      '{32'h0000_0000, 32'h0000_0000, 28'd0, 0, 0},
      '{32'h4000_0000, 32'h0000_0000, 28'd0, 0, 0},
      '{32'hC000_0000, 32'h4000_0000, 28'd0, 0, 0},
      '{32'h3FFF_FFFF, 32'hC000_0000, -28'sd10000000, 0, 0},
      '{32'h4000_0001, 32'h8000_0000, 28'sd100000000, 0, 0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 28'h7FF_FFFF, 0, 0},
      '{32'h8000_0000, 32'h8000_0001, 28'h800_0000, 0, 0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 28'hFFF_FFFF, 0, 0},
      '{32'h2AAA_AAAB, 32'h1555_5555, 28'd1, 0, 0},
      '{32'hD555_5555, 32'hBFFF_FFFF, 28'd8848000, 0, 0},
      '{32'h2000_0000, 32'h6000_0000, 28'd0, 0, 0},
      // Saturation on the largest axis and zero flattening
      '{32'h0000_0000, 32'h0000_0000, 28'd0, 1, 64'sd8000000000},
      '{32'h0000_0000, 32'h8000_0000, 28'd0, 1, -64'sd8000000000},
      '{32'h0000_0000, 32'h0000_0000, 28'h7FF_FFFF, 1, 64'sd8000000000},
      '{32'h0000_0000, 32'h8000_0000, -28'sd10000000, 1, -64'sd8000000000}
    };
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      if (rw.sat && !dir_rows[i - 1].sat) begin
        drain();
        write_reg(CfgSemiMajor, CfgW'(64'h1_FFFF_FFFF));
        write_reg(CfgFlattening, '0);
      end
      typed_x_next = rw.sat;
      typed_x_val = rw.x_sat;
      send_position(rw.lat, rw.lon, rw.h);
    end
    typed_x_next = 1'b0;
    start = 1'b0;

    // Random phases, each on its own ellipsoid, with varied sender pacing
    per = RandItems / 5;
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CfgSemiMajor, CfgW'(64'd6378137000));
          write_reg(CfgFlattening, CfgW'(64'd3686454300));
          idle_pct = 0;
        end
        1: begin
          write_reg(CfgSemiMajor, CfgW'(64'd6000000000));
          write_reg(CfgFlattening, CfgW'(64'd10995116277));
          idle_pct = 61;
        end
        2: begin
          write_reg(CfgSemiMajor, CfgW'(64'd7000000000));
          write_reg(CfgFlattening, '0);
          idle_pct = 23;
        end
        3: begin
          write_reg(CfgSemiMajor, '0);
          write_reg(CfgFlattening, '1);
          idle_pct = 61;
        end
        default: begin
          write_reg(CfgSemiMajor, CfgW'({$urandom, $urandom}));
          write_reg(CfgFlattening, CfgW'({$urandom, $urandom}));
          idle_pct = 0;
        end
      endcase
      run_random(per / 2);
      // Hold the sender until the pipeline is empty once
      if (ph == 2) begin
        start = 1'b0;
        while (pending_ecef.size() != 0) @(negedge clk_i);
      end
      run_random(per - per / 2);
    end

    drain();
    $display("Sent %0d positions over six ellipsoid settings, %0d results checked",
             positions_sent, positions_checked);
    $display("Sender pacing covered back-to-back, 23%% and 61%% idle, and a full drain");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
